@@ rtl/core/spr_pkg.sv @@
package spr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS = 16;

    localparam int ANG_W = 35;
    localparam int Z_W = 32;
    localparam int XY_W = FRAC_BITS + 3;
    localparam int VRAD_W = 23;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_EYE_SELECT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ABSOLUTE_MODE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INTEROCULAR = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_PARALLAX = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_SPAN = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_VERT_SPAN = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_START = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_VERT_START = CFG_IDX_W'(7);

    localparam logic [1:0] EYE_LEFT = 2'd0;
    localparam logic [1:0] EYE_RIGHT = 2'd1;

    localparam logic signed [15:0] HSPAN_FULL = 16'sd23040;
    localparam logic signed [14:0] VSPAN_FULL = 15'sd11520;

    localparam longint ANG_FULL_L = 64'sd1509949440;
    localparam logic signed [ANG_W-1:0] ANG_FULL = ANG_W'(ANG_FULL_L);
    localparam logic signed [ANG_W-1:0] ANG_FULL2 = ANG_W'(2 * ANG_FULL_L);
    localparam logic signed [ANG_W-1:0] ANG_FULL3 = ANG_W'(3 * ANG_FULL_L);
    localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(ANG_FULL_L / 2);
    localparam logic signed [ANG_W-1:0] ANG_QTR = ANG_W'(ANG_FULL_L / 4);
    localparam logic signed [ANG_W-1:0] ANG_QTR3 = ANG_W'(3 * (ANG_FULL_L / 4));

    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam logic signed [XY_W-1:0] X_INIT =
        XY_W'((GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

    localparam logic [VRAD_W-1:0] VRAD_MAX = {VRAD_W{1'b1}};

    typedef struct packed {
        logic signed [ANG_W-1:0] ua;
        logic signed [ANG_W-1:0] va;
        logic                    invalid;
        logic                    offset_en;
        logic                    right;
    } q_item_t;

    function automatic logic signed [Z_W-1:0] atan_val(input int unsigned idx);
        case (idx)
            0: return Z_W'(188743680);
            1: return Z_W'(111421900);
            2: return Z_W'(58872272);
            3: return Z_W'(29884485);
            4: return Z_W'(15000234);
            5: return Z_W'(7507429);
            6: return Z_W'(3754631);
            7: return Z_W'(1877430);
            8: return Z_W'(938729);
            9: return Z_W'(469366);
            10: return Z_W'(234683);
            11: return Z_W'(117342);
            12: return Z_W'(58671);
            13: return Z_W'(29335);
            14: return Z_W'(14668);
            15: return Z_W'(7334);
            16: return Z_W'(3667);
            17: return Z_W'(1833);
            18: return Z_W'(917);
            19: return Z_W'(458);
            20: return Z_W'(229);
            21: return Z_W'(115);
            22: return Z_W'(57);
            23: return Z_W'(29);
            default: return '0;
        endcase
    endfunction

endpackage

@@ rtl/core/spr_front.sv @@
module spr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [15:0]                         u_frac,
    input  logic [15:0]                         v_frac,
    output spr_pkg::q_item_t                    item,
    output logic [15:0]                         io,
    output logic [15:0]                         zp,
    output logic                                radius_start
);

    logic [1:0]         eye_reg;
    logic               abs_reg;
    logic [15:0]        io_reg;
    logic [15:0]        zp_reg;
    logic signed [15:0] hspan_reg;
    logic signed [14:0] vspan_reg;
    logic signed [15:0] hstart_reg;
    logic signed [14:0] vstart_reg;

    logic signed [spr_pkg::ANG_W-1:0] prod_u;
    logic signed [spr_pkg::ANG_W-1:0] prod_v;
    logic signed [spr_pkg::ANG_W-1:0] off_u;
    logic signed [spr_pkg::ANG_W-1:0] off_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg    <= 2'd0;
            abs_reg    <= 1'b0;
            io_reg     <= 16'd0;
            zp_reg     <= 16'd0;
            hspan_reg  <= spr_pkg::HSPAN_FULL;
            vspan_reg  <= spr_pkg::VSPAN_FULL;
            hstart_reg <= 16'sd0;
            vstart_reg <= 15'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spr_pkg::REG_EYE_SELECT:    eye_reg    <= cfg_data[1:0];
                spr_pkg::REG_ABSOLUTE_MODE: abs_reg    <= cfg_data[0];
                spr_pkg::REG_INTEROCULAR:   io_reg     <= cfg_data;
                spr_pkg::REG_ZERO_PARALLAX: zp_reg     <= cfg_data;
                spr_pkg::REG_HORIZ_SPAN:    hspan_reg  <= $signed(cfg_data);
                spr_pkg::REG_VERT_SPAN:     vspan_reg  <= $signed(cfg_data[14:0]);
                spr_pkg::REG_HORIZ_START:   hstart_reg <= $signed(cfg_data);
                spr_pkg::REG_VERT_START:    vstart_reg <= $signed(cfg_data[14:0]);
                default: ;
            endcase
        end
    end

    assign radius_start = cfg_we && (cfg_index == spr_pkg::REG_INTEROCULAR ||
                                     cfg_index == spr_pkg::REG_ZERO_PARALLAX);
    assign io = io_reg;
    assign zp = zp_reg;

    always_comb
    begin
        prod_u = spr_pkg::ANG_W'(hspan_reg) * $signed(spr_pkg::ANG_W'({1'b0, u_frac}));
        prod_v = spr_pkg::ANG_W'(vspan_reg) * $signed(spr_pkg::ANG_W'({1'b0, v_frac}));
        if (abs_reg)
        begin
            off_u = spr_pkg::ANG_W'(hstart_reg) <<< 16;
            off_v = spr_pkg::ANG_W'(vstart_reg) <<< 16;
        end
        else
        begin
            off_u = (spr_pkg::ANG_W'(spr_pkg::HSPAN_FULL) - spr_pkg::ANG_W'(hspan_reg)) <<< 15;
            off_v = (spr_pkg::ANG_W'(spr_pkg::VSPAN_FULL) - spr_pkg::ANG_W'(vspan_reg)) <<< 15;
        end
        item.ua        = prod_u + off_u;
        item.va        = prod_v + off_v;
        item.invalid   = abs_reg && (hspan_reg <= 16'sd0 || vspan_reg <= 15'sd0);
        item.offset_en = (eye_reg == spr_pkg::EYE_LEFT) || (eye_reg == spr_pkg::EYE_RIGHT);
        item.right     = (eye_reg == spr_pkg::EYE_RIGHT);
    end

endmodule

@@ rtl/core/spr_radius.sv @@
module spr_radius (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [15:0]                   io,
    input  logic [15:0]                   zp,
    output logic                          busy,
    output logic [spr_pkg::VRAD_W-1:0]    vrad
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQA  = 3'd3;
    localparam logic [2:0] ST_SQB  = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]                  state_reg;
    logic [5:0]                  cnt_reg;
    logic [31:0]                 ii_reg;
    logic [15:0]                 rem_reg;
    logic [37:0]                 dq_reg;
    logic [59:0]                 asq_reg;
    logic [63:0]                 acc_reg;
    logic [63:0]                 root_reg;
    logic [63:0]                 bit_reg;
    logic [spr_pkg::VRAD_W-1:0]  vrad_reg;

    logic [31:0] ii_w;
    logic [16:0] rem_sh;
    logic        qbit;
    logic [59:0] asq_w;
    logic [61:0] bsq_w;
    logic [63:0] trial;

    assign ii_w   = io * io;
    assign rem_sh = {rem_reg, dq_reg[37]};
    assign qbit   = (rem_sh >= {1'b0, zp});
    assign asq_w  = ii_reg[31:2] * ii_reg[31:2];
    assign bsq_w  = dq_reg[30:0] * dq_reg[30:0];
    assign trial  = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vrad_reg  <= '0;
            cnt_reg   <= 6'd0;
        end
        else if (start)
        begin
            state_reg <= ST_SQR;
        end
        else
        begin
            case (state_reg)
                ST_SQR:
                begin
                    if (zp == 16'd0)
                    begin
                        vrad_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg   <= 6'd37;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_SQA;
                    end
                end
                ST_SQA:
                begin
                    if (dq_reg[37:31] != 7'd0)
                    begin
                        vrad_reg  <= spr_pkg::VRAD_MAX;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_SQB;
                    end
                end
                ST_SQB:
                begin
                    cnt_reg   <= 6'd31;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (root_reg[63:31] != 33'd0)
                    begin
                        vrad_reg <= spr_pkg::VRAD_MAX;
                    end
                    else
                    begin
                        vrad_reg <= root_reg[30:8];
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SQR:
            begin
                ii_reg  <= ii_w;
                dq_reg  <= {ii_w, 6'd0};
                rem_reg <= 16'd0;
            end
            ST_DIV:
            begin
                if (qbit)
                begin
                    rem_reg <= 16'(rem_sh - {1'b0, zp});
                end
                else
                begin
                    rem_reg <= rem_sh[15:0];
                end
                dq_reg <= {dq_reg[36:0], qbit};
            end
            ST_SQA:
            begin
                asq_reg <= asq_w;
            end
            ST_SQB:
            begin
                acc_reg  <= 64'(asq_reg) + 64'(bsq_w);
                root_reg <= 64'd0;
                bit_reg  <= 64'd1 << 62;
            end
            ST_ROOT:
            begin
                if (acc_reg >= trial)
                begin
                    acc_reg  <= acc_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign vrad = vrad_reg;

endmodule

@@ rtl/core/spr_fifo.sv @@
module spr_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  spr_pkg::q_item_t  wdata,
    output logic              full,
    input  logic              rd,
    output spr_pkg::q_item_t  rdata,
    output logic              empty
);

    spr_pkg::q_item_t           mem_reg [0:spr_pkg::Q_DEPTH-1];
    logic [spr_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [spr_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [spr_pkg::Q_PTR_W:0]   count_reg;
    logic                        do_wr;
    logic                        do_rd;

    assign full  = (count_reg == (spr_pkg::Q_PTR_W + 1)'(spr_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/spr_back.sv @@
module spr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spr_pkg::q_item_t              q_data,
    input  logic                          q_empty,
    output logic                          q_rd,
    input  logic [spr_pkg::VRAD_W-1:0]    vrad,
    input  logic                          pop,
    output logic                          empty,
    output logic signed [15:0]            dir_x,
    output logic signed [15:0]            dir_y,
    output logic signed [15:0]            dir_z,
    output logic signed [23:0]            orig_x,
    output logic signed [23:0]            orig_z,
    output logic                          valid_res
);

    localparam int N      = spr_pkg::CORDIC_STAGES;
    localparam int FB     = spr_pkg::FRAC_BITS;
    localparam int XY     = spr_pkg::XY_W;
    localparam int XY1    = XY + 1;
    localparam int ZW     = spr_pkg::Z_W;
    localparam int AW     = spr_pkg::ANG_W;
    localparam int PD_W   = 2 * XY;
    localparam int PD_X   = PD_W + 1;
    localparam int DIR_SH = 2 * FB - 14;
    localparam int VR_S   = spr_pkg::VRAD_W + 1;
    localparam int OP_W   = VR_S + XY1;
    localparam int ORG_W  = OP_W + 1;

    localparam logic signed [PD_X-1:0]  DIR_RND = PD_X'(1) <<< (DIR_SH - 1);
    localparam logic signed [PD_X-1:0]  DIR_HI  = PD_X'(16384);
    localparam logic signed [PD_X-1:0]  DIR_LO  = -PD_X'(16384);
    localparam logic signed [OP_W-1:0]  ORG_RND = OP_W'(1) <<< (FB - 1);
    localparam logic signed [ORG_W-1:0] ORG_HI  = ORG_W'(8388607);
    localparam logic signed [ORG_W-1:0] ORG_LO  = -ORG_W'(8388608);
    localparam logic signed [XY1-1:0]   ONE     = XY1'(1) <<< FB;

    function automatic logic signed [15:0] to_q14(input logic signed [PD_X-1:0] p);
        logic signed [PD_X-1:0] r;
        r = (p + DIR_RND) >>> DIR_SH;
        if (r > DIR_HI)
        begin
            return 16'sd16384;
        end
        else if (r < DIR_LO)
        begin
            return -16'sd16384;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [23:0] to_org(input logic signed [OP_W-1:0] p,
                                                  input logic neg);
        logic signed [OP_W-1:0]  r;
        logic signed [ORG_W-1:0] s;
        r = (p + ORG_RND) >>> FB;
        s = neg ? -ORG_W'(r) : ORG_W'(r);
        if (s > ORG_HI)
        begin
            return 24'sd8388607;
        end
        else if (s < ORG_LO)
        begin
            return -24'sd8388608;
        end
        return s[23:0];
    endfunction

    function automatic logic [ZW:0] fold(input logic signed [AW-1:0] t);
        logic signed [AW-1:0] z;
        logic                 neg;
        if (t <= spr_pkg::ANG_QTR)
        begin
            z   = t;
            neg = 1'b0;
        end
        else if (t < spr_pkg::ANG_QTR3)
        begin
            z   = t - spr_pkg::ANG_HALF;
            neg = 1'b1;
        end
        else
        begin
            z   = t - spr_pkg::ANG_FULL;
            neg = 1'b0;
        end
        return {neg, z[ZW-1:0]};
    endfunction

    logic en;
    logic out_valid_reg;

    spr_pkg::q_item_t ra_reg, rb_reg, rc_reg;
    logic             ra_v_reg, rb_v_reg, rc_v_reg;

    logic signed [XY-1:0] ux_reg [0:N];
    logic signed [XY-1:0] uy_reg [0:N];
    logic signed [XY-1:0] vx_reg [0:N];
    logic signed [XY-1:0] vy_reg [0:N];
    logic signed [ZW-1:0] uz_reg [0:N];
    logic signed [ZW-1:0] vz_reg [0:N];
    logic                 un_reg [0:N];
    logic                 vn_reg [0:N];
    logic                 inv_reg [0:N];
    logic                 oen_reg [0:N];
    logic                 rt_reg [0:N];
    logic                 cv_v_reg [0:N];

    logic [ZW:0] fold_u;
    logic [ZW:0] fold_v;

    logic signed [XY-1:0] cu_reg, su_reg, cvv_reg, sv_reg;
    logic                 p1_v_reg, p1_inv_reg, p1_oen_reg, p1_rt_reg;

    logic signed [PD_W-1:0] px_reg, pz_reg;
    logic signed [XY-1:0]   cv2_reg;
    logic signed [OP_W-1:0] pox_reg, poz_reg;
    logic                   p2_v_reg, p2_inv_reg, p2_oen_reg, p2_rt_reg;

    logic signed [VR_S-1:0] vr_s;
    logic signed [XY1-1:0]  ocu;

    logic signed [15:0] dx_w, dy_w, dz_w;
    logic signed [23:0] ox_w, oz_w;

    logic signed [15:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic signed [23:0] orig_x_reg, orig_z_reg;
    logic               valid_res_reg;

    assign en    = !out_valid_reg || pop;
    assign q_rd  = en && !q_empty;
    assign empty = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_v_reg      <= 1'b0;
            rb_v_reg      <= 1'b0;
            rc_v_reg      <= 1'b0;
            cv_v_reg[0]   <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ra_v_reg      <= !q_empty;
            rb_v_reg      <= ra_v_reg;
            rc_v_reg      <= rb_v_reg;
            cv_v_reg[0]   <= rc_v_reg;
            p1_v_reg      <= cv_v_reg[N];
            p2_v_reg      <= p1_v_reg;
            out_valid_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg.invalid   <= q_data.invalid;
            ra_reg.offset_en <= q_data.offset_en;
            ra_reg.right     <= q_data.right;
            ra_reg.ua <= (q_data.ua < 0) ? q_data.ua + spr_pkg::ANG_FULL3 : q_data.ua;
            ra_reg.va <= (q_data.va < 0) ? q_data.va + spr_pkg::ANG_FULL3 : q_data.va;

            rb_reg.invalid   <= ra_reg.invalid;
            rb_reg.offset_en <= ra_reg.offset_en;
            rb_reg.right     <= ra_reg.right;
            rb_reg.ua <= (ra_reg.ua >= spr_pkg::ANG_FULL2) ?
                         ra_reg.ua - spr_pkg::ANG_FULL2 : ra_reg.ua;
            rb_reg.va <= (ra_reg.va >= spr_pkg::ANG_FULL2) ?
                         ra_reg.va - spr_pkg::ANG_FULL2 : ra_reg.va;

            rc_reg.invalid   <= rb_reg.invalid;
            rc_reg.offset_en <= rb_reg.offset_en;
            rc_reg.right     <= rb_reg.right;
            rc_reg.ua <= (rb_reg.ua >= spr_pkg::ANG_FULL) ?
                         rb_reg.ua - spr_pkg::ANG_FULL : rb_reg.ua;
            rc_reg.va <= (rb_reg.va >= spr_pkg::ANG_FULL) ?
                         rb_reg.va - spr_pkg::ANG_FULL : rb_reg.va;
        end
    end

    assign fold_u = fold(rc_reg.ua);
    assign fold_v = fold(rc_reg.va);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg[0]  <= spr_pkg::X_INIT;
            uy_reg[0]  <= '0;
            vx_reg[0]  <= spr_pkg::X_INIT;
            vy_reg[0]  <= '0;
            uz_reg[0]  <= $signed(fold_u[ZW-1:0]);
            vz_reg[0]  <= $signed(fold_v[ZW-1:0]);
            un_reg[0]  <= fold_u[ZW];
            vn_reg[0]  <= fold_v[ZW];
            inv_reg[0] <= rc_reg.invalid;
            oen_reg[0] <= rc_reg.offset_en;
            rt_reg[0]  <= rc_reg.right;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cv_v_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    cv_v_reg[i+1] <= cv_v_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (uz_reg[i] >= 0)
                    begin
                        ux_reg[i+1] <= ux_reg[i] - (uy_reg[i] >>> i);
                        uy_reg[i+1] <= uy_reg[i] + (ux_reg[i] >>> i);
                        uz_reg[i+1] <= uz_reg[i] - spr_pkg::atan_val(i);
                    end
                    else
                    begin
                        ux_reg[i+1] <= ux_reg[i] + (uy_reg[i] >>> i);
                        uy_reg[i+1] <= uy_reg[i] - (ux_reg[i] >>> i);
                        uz_reg[i+1] <= uz_reg[i] + spr_pkg::atan_val(i);
                    end
                    if (vz_reg[i] >= 0)
                    begin
                        vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                        vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                        vz_reg[i+1] <= vz_reg[i] - spr_pkg::atan_val(i);
                    end
                    else
                    begin
                        vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                        vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                        vz_reg[i+1] <= vz_reg[i] + spr_pkg::atan_val(i);
                    end
                    un_reg[i+1]  <= un_reg[i];
                    vn_reg[i+1]  <= vn_reg[i];
                    inv_reg[i+1] <= inv_reg[i];
                    oen_reg[i+1] <= oen_reg[i];
                    rt_reg[i+1]  <= rt_reg[i];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cu_reg  <= un_reg[N] ? -ux_reg[N] : ux_reg[N];
            su_reg  <= un_reg[N] ? -uy_reg[N] : uy_reg[N];
            cvv_reg <= vn_reg[N] ? -vx_reg[N] : vx_reg[N];
            if ((vn_reg[N] ? -vy_reg[N] : vy_reg[N]) < 0)
            begin
                sv_reg <= vn_reg[N] ? vy_reg[N] : -vy_reg[N];
            end
            else
            begin
                sv_reg <= vn_reg[N] ? -vy_reg[N] : vy_reg[N];
            end
            p1_inv_reg <= inv_reg[N];
            p1_oen_reg <= oen_reg[N];
            p1_rt_reg  <= rt_reg[N];
        end
    end

    assign vr_s = $signed({1'b0, vrad});
    assign ocu  = XY1'(cu_reg) + ONE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg     <= su_reg * sv_reg;
            pz_reg     <= cu_reg * sv_reg;
            cv2_reg    <= cvv_reg;
            pox_reg    <= vr_s * ocu;
            poz_reg    <= vr_s * su_reg;
            p2_inv_reg <= p1_inv_reg;
            p2_oen_reg <= p1_oen_reg;
            p2_rt_reg  <= p1_rt_reg;
        end
    end

    always_comb
    begin
        dx_w = to_q14(-PD_X'(px_reg));
        dy_w = to_q14(-(PD_X'(cv2_reg) <<< FB));
        dz_w = to_q14(PD_X'(pz_reg));
        ox_w = to_org(pox_reg, p2_rt_reg);
        oz_w = to_org(poz_reg, p2_rt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (p2_inv_reg)
            begin
                dir_x_reg     <= '0;
                dir_y_reg     <= '0;
                dir_z_reg     <= '0;
                orig_x_reg    <= '0;
                orig_z_reg    <= '0;
                valid_res_reg <= 1'b0;
            end
            else
            begin
                dir_x_reg     <= dx_w;
                dir_y_reg     <= dy_w;
                dir_z_reg     <= dz_w;
                orig_x_reg    <= p2_oen_reg ? ox_w : '0;
                orig_z_reg    <= p2_oen_reg ? oz_w : '0;
                valid_res_reg <= 1'b1;
            end
        end
    end

    assign dir_x     = dir_x_reg;
    assign dir_y     = dir_y_reg;
    assign dir_z     = dir_z_reg;
    assign orig_x    = orig_x_reg;
    assign orig_z    = orig_z_reg;
    assign valid_res = valid_res_reg;

endmodule

@@ rtl/core/stereo_panorama_ray_generator_core.sv @@
// Path: a transaction pushed into the queue passes the angle reduction registers (ra, rb, rc),
// the CORDIC stage registers, the product registers (p1, p2) and the output register.
// Throughput: one transaction per cycle via the CORDIC pair; an unpopped result stalls it all.
// After a write of interocular or zero_parallax, full stays high while the eye radius unit
// runs its serial divide and square root; it ends early when zero_parallax is zero or when
// the quotient overflows.
// Reset is asynchronous and active low; the queues empty and registers take their defaults.
module stereo_panorama_ray_generator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [15:0]                       u_frac,
    input  logic [15:0]                       v_frac,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [15:0]                dir_x,
    output logic signed [15:0]                dir_y,
    output logic signed [15:0]                dir_z,
    output logic signed [23:0]                orig_x,
    output logic signed [23:0]                orig_z,
    output logic                              valid_res
);

    spr_pkg::q_item_t            item;
    spr_pkg::q_item_t            q_data;
    logic [15:0]                 io;
    logic [15:0]                 zp;
    logic                        radius_start;
    logic                        radius_busy;
    logic [spr_pkg::VRAD_W-1:0]  vrad;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_rd;

    assign full = q_full || radius_busy;

    spr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .u_frac       (u_frac),
        .v_frac       (v_frac),
        .item         (item),
        .io           (io),
        .zp           (zp),
        .radius_start (radius_start)
    );

    spr_radius u_radius (
        .clk   (clk),
        .rst_n (rst_n),
        .start (radius_start),
        .io    (io),
        .zp    (zp),
        .busy  (radius_busy),
        .vrad  (vrad)
    );

    spr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push && !radius_busy),
        .wdata (item),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_data),
        .empty (q_empty)
    );

    spr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .vrad      (vrad),
        .pop       (pop),
        .empty     (empty),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .orig_x    (orig_x),
        .orig_z    (orig_z),
        .valid_res (valid_res)
    );

endmodule
